[rtl/rmth_pkg.sv]
// Shared types, constants and helpers for the two-heap running median block.
package rmth_pkg;

	localparam int DATA_W       = 32;
	localparam int MED_W        = 33;
	localparam int CAPACITY_DEF = 1024;

	typedef logic signed [DATA_W-1:0] data_t;

	// Operation applied to every cell of a chain at the same clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH_LO,
		ST_MOVE_UP,
		ST_REBAL,
		ST_REPORT
	} state_t;

	// True when a ranks above b: larger for the max side, smaller for the min side.
	function automatic logic above(input data_t a, input data_t b, input logic is_max);
		above = is_max ? (a > b) : (a < b);
	endfunction

endpackage

[rtl/rmth_cell.sv]
// One cell of a sorted chain: holds one value, inserts or shifts with its neighbors.
module rmth_cell #(
	parameter int  INDEX  = 0,
	parameter int  CNT_W  = 10,
	parameter bit  IS_MAX = 1'b1
) (
	input  logic                 clk,
	input  rmth_pkg::cell_op_t   op,
	input  rmth_pkg::data_t      v,
	input  logic [CNT_W-1:0]     count,
	input  logic                 g_prev,
	input  rmth_pkg::data_t      c_prev,
	input  rmth_pkg::data_t      c_next,
	output logic                 g,
	output rmth_pkg::data_t      c
);
	import rmth_pkg::*;

	data_t c_q;
	logic  occ;

	assign occ = CNT_W'(INDEX) < count;
	// new value belongs at or before this cell
	assign g   = !occ || above(v, c_q, IS_MAX);
	assign c   = c_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_INSERT: begin
				if (g) begin
					c_q <= g_prev ? c_prev : v;
				end
			end
			CELL_POP: c_q <= c_next;
			CELL_HOLD: c_q <= c_q;
			default: c_q <= c_q;
		endcase
	end

endmodule

[rtl/rmth_chain.sv]
// Row of cells forming one sorted half; the top of the half sits in cell 0.
module rmth_chain #(
	parameter int DEPTH  = 513,
	parameter int CNT_W  = 10,
	parameter bit IS_MAX = 1'b1
) (
	input  logic               clk,
	input  rmth_pkg::cell_op_t op,
	input  rmth_pkg::data_t    v,
	input  logic [CNT_W-1:0]   count,
	output rmth_pkg::data_t    top
);
	import rmth_pkg::*;

	data_t c   [DEPTH];
	logic  g   [DEPTH];

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic  gp;
			data_t cp;
			data_t cn;
			if (i == 0) begin : g_first
				assign gp = 1'b0;
				assign cp = v;
			end else begin : g_mid
				assign gp = g[i-1];
				assign cp = c[i-1];
			end
			if (i == DEPTH-1) begin : g_last
				assign cn = c[i];
			end else begin : g_inner
				assign cn = c[i+1];
			end
			rmth_cell #(
				.INDEX (i),
				.CNT_W (CNT_W),
				.IS_MAX(IS_MAX)
			) u_cell (
				.clk   (clk),
				.op    (op),
				.v     (v),
				.count (count),
				.g_prev(gp),
				.c_prev(cp),
				.c_next(cn),
				.g     (g[i]),
				.c     (c[i])
			);
		end
	endgenerate

	assign top = c[0];

endmodule

[rtl/running_median_two_heaps_top.sv]
// Top level of the running median block: sequencer, counts and result register.
//
// Usage: present a signed 32-bit sample and raise start; the transfer happens
// at the rising edge where start is high and busy is low. One result follows
// per accepted sample: done is high for exactly one cycle while median_doubled
// (twice the median, 33-bit signed), element_count and dropped are valid.
// The receiver cannot stall; a result must be taken in its cycle.
//
// The samples are kept in two sorted chains of cells: the lower half in
// descending order and the upper half in ascending order, so each half's
// top sits in its first cell. Every cell compares the incoming value with
// its own and takes its left neighbor's value, the new value or keeps its
// own, so an insert or a removal of the top acts on all cells together.
// An accepted sample costs three chain steps (push into lower, move lower
// top up, optional move back) plus a report step, and busy stays high
// until they are through, so a new sample is taken only after the last
// one is done. When CAPACITY samples are held, a new sample is dropped:
// the sequencer goes straight to the report step, and done then rises with
// the unchanged median and dropped set.
// Reset (arst_n low) empties both halves; cell contents are not cleared,
// only the counts, which mark which cells hold samples.
module running_median_two_heaps_top #(
	parameter int CAPACITY = rmth_pkg::CAPACITY_DEF,
	parameter int TOT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  rmth_pkg::data_t                   sample,
	output logic                              done,
	output logic signed [rmth_pkg::MED_W-1:0] median_doubled,
	output logic [TOT_W-1:0]                  element_count,
	output logic                              dropped
);
	import rmth_pkg::*;

	// each half holds at most half the capacity plus one during a move
	localparam int DEPTH = CAPACITY / 2 + 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  lo_cnt_q, up_cnt_q;
	logic [CNT_W-1:0]  lo_cnt_d, up_cnt_d;
	data_t             sample_q;
	logic              drop_q;
	logic              done_q;
	logic signed [MED_W-1:0] med_q;
	logic [TOT_W-1:0]  total_q;

	cell_op_t          lo_op, up_op;
	data_t             lo_v, up_v;
	data_t             lo_top, up_top;
	logic [TOT_W-1:0]  total;
	logic              accept;
	logic signed [MED_W-1:0] med;

	assign total  = TOT_W'(lo_cnt_q) + TOT_W'(up_cnt_q);
	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;

	rmth_chain #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W),
		.IS_MAX(1'b1)
	) u_lower (
		.clk  (clk),
		.op   (lo_op),
		.v    (lo_v),
		.count(lo_cnt_q),
		.top  (lo_top)
	);

	rmth_chain #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W),
		.IS_MAX(1'b0)
	) u_upper (
		.clk  (clk),
		.op   (up_op),
		.v    (up_v),
		.count(up_cnt_q),
		.top  (up_top)
	);

	// sequencer: next state, chain operations and count updates
	always_comb begin
		state_d  = state_q;
		lo_op    = CELL_HOLD;
		up_op    = CELL_HOLD;
		lo_v     = sample_q;
		up_v     = lo_top;
		lo_cnt_d = lo_cnt_q;
		up_cnt_d = up_cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (total >= TOT_W'(CAPACITY)) ? ST_REPORT : ST_PUSH_LO;
				end
			end
			ST_PUSH_LO: begin
				lo_op    = CELL_INSERT;
				lo_cnt_d = lo_cnt_q + CNT_W'(1);
				state_d  = ST_MOVE_UP;
			end
			ST_MOVE_UP: begin
				// lower top leaves the lower half and enters the upper half
				lo_op    = CELL_POP;
				up_op    = CELL_INSERT;
				lo_cnt_d = lo_cnt_q - CNT_W'(1);
				up_cnt_d = up_cnt_q + CNT_W'(1);
				state_d  = ST_REBAL;
			end
			ST_REBAL: begin
				// lower half keeps the extra element
				if (lo_cnt_q < up_cnt_q) begin
					lo_op    = CELL_INSERT;
					lo_v     = up_top;
					up_op    = CELL_POP;
					lo_cnt_d = lo_cnt_q + CNT_W'(1);
					up_cnt_d = up_cnt_q - CNT_W'(1);
				end
				state_d = ST_REPORT;
			end
			ST_REPORT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// median from the two tops; zero when empty, odd count or empty upper half uses lower top twice
	always_comb begin
		if (lo_cnt_q == '0) begin
			med = '0;
		end else if (lo_cnt_q > up_cnt_q || up_cnt_q == '0) begin
			med = MED_W'(lo_top) + MED_W'(lo_top);
		end else begin
			med = MED_W'(lo_top) + MED_W'(up_top);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lo_cnt_q <= '0;
			up_cnt_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			lo_cnt_q <= lo_cnt_d;
			up_cnt_q <= up_cnt_d;
			done_q   <= state_q == ST_REPORT;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			drop_q   <= total >= TOT_W'(CAPACITY);
		end
		if (state_q == ST_REPORT) begin
			med_q   <= med;
			total_q <= total;
		end
	end

	assign done           = done_q;
	assign median_doubled = med_q;
	assign element_count  = total_q;
	assign dropped        = drop_q;

endmodule

[tb/tb_running_median_two_heaps_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the two-heap running median block.
module tb_running_median_two_heaps_top;
	import rmth_pkg::*;

	localparam int CNT_W       = $clog2(CAPACITY_DEF + 1);
	localparam int PHASE_ITEMS = 560;   // three random phases, about 1700 items in all
	localparam int STALL_LIMIT = 1000;  // cycles without any transfer or result
	localparam int TAIL_CYCLES = 20;
	localparam int MAX_REPORTS = 10;

	// One result as the block reports it.
	typedef struct packed {
		logic signed [MED_W-1:0] median;
		logic [CNT_W-1:0]        count;
		logic                    dropped;
	} median_result_t;

	// One directed row: sample, whether the expected result is typed in, and that result.
	typedef struct packed {
		data_t          value;
		logic           literal;
		median_result_t want;
	} stim_row_t;

	localparam int N_DIRECTED = 20;

	// First rows start from an empty block, so their results are obvious:
	// min alone, min+max, a middle zero, and a run of max values on top.
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{32'sh8000_0000, 1'b1, '{33'sh1_0000_0000, 11'd1, 1'b0}},  // 2*min
		'{32'sh7FFF_FFFF, 1'b1, '{33'sh1_FFFF_FFFF, 11'd2, 1'b0}},  // min+max = -1
		'{32'sh0000_0000, 1'b1, '{33'sh0_0000_0000, 11'd3, 1'b0}},
		'{32'sh7FFF_FFFF, 1'b1, '{33'sh0_7FFF_FFFF, 11'd4, 1'b0}},  // 0+max
		'{32'sh7FFF_FFFF, 1'b1, '{33'sh0_FFFF_FFFE, 11'd5, 1'b0}},  // 2*max
		'{32'sh8000_0000, 1'b0, '0},
		'{32'sh8000_0000, 1'b0, '0},
		'{32'sh8000_0000, 1'b0, '0},
		'{32'shFFFF_FFFF, 1'b0, '0},
		'{32'sh0000_0001, 1'b0, '0},
		'{32'sh8000_0001, 1'b0, '0},
		'{32'sh7FFF_FFFE, 1'b0, '0},
		'{32'sh5555_5555, 1'b0, '0},
		'{32'shAAAA_AAAA, 1'b0, '0},
		'{32'sh0000_0000, 1'b0, '0},
		'{32'sh0000_0000, 1'b0, '0},
		'{32'sh0000_0064, 1'b0, '0},
		'{32'shFFFF_FF9C, 1'b0, '0},
		'{32'sh1234_5678, 1'b0, '0},
		'{32'shEDCB_A988, 1'b0, '0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	data_t                   sample;
	logic                    done;
	logic signed [MED_W-1:0] median_doubled;
	logic [CNT_W-1:0]        element_count;
	logic                    dropped;

	// All held samples in ascending order. The lower heap is the first
	// ceil(n/2) entries, so its top is the last of those and the upper
	// heap's top is the entry right after it.
	data_t          sorted_pool[$];
	median_result_t expected_q[$];
	int             mismatch_count;
	int             stall_cycles;
	median_result_t got_res;
	median_result_t want_res;

	running_median_two_heaps_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.sample         (sample),
		.done           (done),
		.median_doubled (median_doubled),
		.element_count  (element_count),
		.dropped        (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Insert keeping the pool sorted; equal values go after existing ones,
	// which does not change any top value.
	function automatic void pool_insert(data_t v);
		int idx;
		idx = 0;
		while (idx < sorted_pool.size() && sorted_pool[idx] <= v)
			idx++;
		sorted_pool.insert(idx, v);
	endfunction

	// Applies one sample to the predicted state and returns the result it causes.
	function automatic median_result_t predict_median(data_t v);
		median_result_t          r;
		int                      n;
		int                      lo_n;
		logic signed [MED_W-1:0] lo_top;
		logic signed [MED_W-1:0] hi_top;
		r.dropped = 1'b0;
		// Full: the sample is thrown away, median and count stay as they were.
		if (sorted_pool.size() >= CAPACITY_DEF)
			r.dropped = 1'b1;
		else
			pool_insert(v);
		n      = sorted_pool.size();
		lo_n   = (n + 1) / 2;
		lo_top = sorted_pool[lo_n - 1];
		// Odd count: lower half holds the extra element, median is its top.
		// Even count: both tops, summed at 33 bits so nothing wraps.
		if (n % 2 == 1) begin
			r.median = lo_top + lo_top;
		end else begin
			hi_top   = sorted_pool[lo_n];
			r.median = lo_top + hi_top;
		end
		r.count = n[CNT_W-1:0];
		return r;
	endfunction

	// Mix of extremes, a narrow band around zero (lots of duplicates and
	// ties across the two halves) and full-range values.
	function automatic data_t random_sample();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 3))
				0:       return 32'sh8000_0000;
				1:       return 32'sh7FFF_FFFF;
				2:       return 32'sh0000_0000;
				default: return 32'shFFFF_FFFF;
			endcase
		end else if (pick <= 3) begin
			return $signed($urandom_range(0, 16)) - 8;
		end
		return $urandom;
	endfunction

	// Presents one sample and holds it until the block takes it. The
	// expected result is recorded at the edge of the transfer; a typed-in
	// result replaces the predicted one, but the state still advances.
	task automatic transfer_sample(input data_t v, input logic literal,
			input median_result_t lit);
		median_result_t pred;
		@(negedge clk);
		start  <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pred = predict_median(v);
		expected_q.push_back(literal ? lit : pred);
	endtask

	// Sender goes quiet for a gap set by n; sample wanders meanwhile.
	task automatic idle_gap(input int n);
		@(negedge clk);
		start  <= 1'b0;
		sample <= $urandom;
		repeat (n - 1)
			@(negedge clk);
	endtask

	// Hold off until every expected result has arrived.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Results: the receiver cannot stall, so each done cycle is checked on the spot.
	always @(posedge clk) begin
		if (arst_n && done) begin
			got_res = '{median_doubled, element_count, dropped};
			if (expected_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("mismatch: unexpected result: median %0d count %0d drop %0b",
						got_res.median, got_res.count, got_res.dropped);
			end else begin
				want_res = expected_q.pop_front();
				if (got_res !== want_res) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"mismatch at %0t: median exp %0d got %0d, ",
							"count exp %0d got %0d, drop exp %0b got %0b"},
							$realtime, want_res.median, got_res.median,
							want_res.count, got_res.count,
							want_res.dropped, got_res.dropped);
				end
			end
		end
	end

	// Progress counter: any transfer or result clears it.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		int idle_pct [3];
		int ph;
		int i;
		idle_pct       = '{34, 70, 0};
		start          = 1'b0;
		sample         = '0;
		arst_n         = 1'b0;
		repeat (7)
			@(negedge clk);
		arst_n = 1'b1;

		// Directed rows, back to back from an empty block.
		for (i = 0; i < N_DIRECTED; i++)
			transfer_sample(DIRECTED[i].value, DIRECTED[i].literal, DIRECTED[i].want);
		drain_results();

		// Random phases with different sender idling. The block fills up
		// partway through the second phase; from there on every sample is
		// dropped, which checks that the median stays frozen.
		for (ph = 0; ph < 3; ph++) begin
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 99) < idle_pct[ph])
					idle_gap($urandom_range(1, 8));
				transfer_sample(random_sample(), 1'b0, '0);
			end
			// Sender pauses until the block has reported everything.
			drain_results();
		end

		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
